// ----- rtl/core/cbq_pkg.sv -----
`default_nettype none

package cbq_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_BITS    = 32;
	localparam int FRAC_BITS    = 28;
	localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS;
	// five products of at most 2^54 each, plus rounding offset
	localparam int ACC_BITS     = PROD_BITS + 2;
	localparam int NUM_SECTIONS = 6;
	localparam int SEC_BITS     = $clog2(NUM_SECTIONS);

	// configuration register file
	localparam int CFG_IDX_BITS = 3;
	localparam int EXTRA_BITS   = 3;
	localparam int ORDER_BITS   = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_B0     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_B1     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B2     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_A1     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_A2     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXTRA  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORDER  = 3'd6;

	localparam logic [ORDER_BITS-1:0] ORDER_FIRST  = 2'd1;
	localparam logic [ORDER_BITS-1:0] ORDER_SECOND = 2'd2;

	localparam logic signed [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1) <<< FRAC_BITS;

	// tap order inside one section
	localparam int TAP_BITS = 3;
	localparam logic [TAP_BITS-1:0] TAP_B0 = 3'd0;
	localparam logic [TAP_BITS-1:0] TAP_B1 = 3'd1;
	localparam logic [TAP_BITS-1:0] TAP_A1 = 3'd2;
	localparam logic [TAP_BITS-1:0] TAP_B2 = 3'd3;
	localparam logic [TAP_BITS-1:0] TAP_A2 = 3'd4;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic issue;
		logic first;
	} mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/cbq_stream_if.sv -----
`default_nettype none

interface cbq_in_if;
	import cbq_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
	import cbq_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cbq_mac.sv -----
`default_nettype none

module cbq_mac (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire cbq_pkg::mac_ctrl_t                     ctrl,
	input  wire logic signed [cbq_pkg::COEF_BITS-1:0]   coef,
	input  wire logic signed [cbq_pkg::SAMPLE_BITS-1:0] smp,
	output logic signed [cbq_pkg::SAMPLE_BITS-1:0]      y
);
	import cbq_pkg::*;

	localparam int RND_BITS = ACC_BITS - FRAC_BITS;

	localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [RND_BITS-1:0] SAT_MAX  =
		RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_BITS-1:0] SAT_MIN  = -SAT_MAX - RND_BITS'(1);

	logic signed [PROD_BITS-1:0] prod_full;
	logic signed [PROD_BITS-1:0] prod_s1;
	mac_ctrl_t                   ctrl_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  prod_ext;
	logic signed [ACC_BITS-1:0]  acc_rnd;
	logic signed [RND_BITS-1:0]  acc_int;

	// full-width signed product of the selected tap
	assign prod_full = coef * smp;

	// stage 1: product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			prod_s1 <= prod_full;
		end
	end

	// stage 2: accumulate, restarting on the first tap of a section
	assign prod_ext = ACC_BITS'(prod_s1);

	always_ff @(posedge clk) begin
		if (ctrl_s1.issue) begin
			acc_q <= ctrl_s1.first ? prod_ext : acc_q + prod_ext;
		end
	end

	// round half up, then saturate to the sample width
	assign acc_rnd = acc_q + RND_HALF;
	assign acc_int = acc_rnd[ACC_BITS-1:FRAC_BITS];

	always_comb begin
		if (acc_int > SAT_MAX) begin
			y = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (acc_int < SAT_MIN) begin
			y = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			y = acc_int[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/cascaded_biquad_filter.sv -----
// channel  | role   | payload                       | request moves
// ---------+--------+-------------------------------+-----------------------------
// dry      | sink   | sample_in, s24                | one sample into the cascade
// wet      | source | sample_out, s24               | one filtered sample
// cfg      | write  | cfg_index 3b, cfg_data 32b    | one register write
//
// one shared 32x24 multiplier and accumulator serve every tap of every section
// a section issues its taps in turn (3 first order, 5 second order), then drains and writes back
// an accepted sample passes each section in use (none in bypass), then the output register
// reset clears coefficients to unity pass-through and all section histories
// dry is not ready until the result has moved into the wet output register

`default_nettype none

module cascaded_biquad_filter (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	cbq_in_if.sink                                      dry,
	cbq_out_if.source                                   wet,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [cbq_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [cbq_pkg::COEF_BITS-1:0]          cfg_data
);
	import cbq_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAC   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_WB    = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	localparam logic [SEC_BITS-1:0] SEC_LAST = SEC_BITS'(NUM_SECTIONS - 1);

	state_t state_q;

	logic signed [COEF_BITS-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [EXTRA_BITS-1:0]         extra_q;
	logic [ORDER_BITS-1:0]         order_q;

	logic signed [SAMPLE_BITS-1:0] xh1_q [NUM_SECTIONS];
	logic signed [SAMPLE_BITS-1:0] xh2_q [NUM_SECTIONS];
	logic signed [SAMPLE_BITS-1:0] yh1_q [NUM_SECTIONS];
	logic signed [SAMPLE_BITS-1:0] yh2_q [NUM_SECTIONS];

	logic [SEC_BITS-1:0]           sec_q;
	logic [TAP_BITS-1:0]           tap_q;
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	logic                          order_ok;
	logic                          second;
	logic [SEC_BITS-1:0]           last_sec;
	logic [TAP_BITS-1:0]           last_tap;
	logic                          in_take;
	logic                          out_load;
	mac_ctrl_t                     mac_ctrl;
	logic signed [COEF_BITS-1:0]   op_coef;
	logic signed [SAMPLE_BITS-1:0] op_smp;
	logic signed [SAMPLE_BITS-1:0] mac_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q    <= COEF_UNITY;
			b1_q    <= '0;
			b2_q    <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
			extra_q <= '0;
			order_q <= ORDER_SECOND;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_B0:    b0_q    <= cfg_data;
				REG_B1:    b1_q    <= cfg_data;
				REG_B2:    b2_q    <= cfg_data;
				REG_A1:    a1_q    <= cfg_data;
				REG_A2:    a2_q    <= cfg_data;
				REG_EXTRA: extra_q <= cfg_data[EXTRA_BITS-1:0];
				REG_ORDER: order_q <= cfg_data[ORDER_BITS-1:0];
				default: ;
			endcase
		end
	end

	// mode decode
	assign second   = (order_q == ORDER_SECOND);
	assign order_ok = (order_q == ORDER_FIRST) || second;
	assign last_tap = second ? TAP_A2 : TAP_A1;
	assign last_sec = (int'(extra_q) >= NUM_SECTIONS - 1) ? SEC_LAST
		: SEC_BITS'(extra_q);

	assign dry.ready = (state_q == ST_IDLE);
	assign in_take   = dry.valid && dry.ready;

	// result moves into the output register when it is free or being taken
	assign out_load  = (state_q == ST_OUT) && (!out_vld_q || wet.ready);

	// operand select for the shared multiplier
	always_comb begin
		unique case (tap_q)
			TAP_B0: begin
				op_coef = b0_q;
				op_smp  = s_q;
			end
			TAP_B1: begin
				op_coef = b1_q;
				op_smp  = xh1_q[sec_q];
			end
			TAP_A1: begin
				op_coef = a1_q;
				op_smp  = yh1_q[sec_q];
			end
			TAP_B2: begin
				op_coef = b2_q;
				op_smp  = xh2_q[sec_q];
			end
			TAP_A2: begin
				op_coef = a2_q;
				op_smp  = yh2_q[sec_q];
			end
			default: begin
				op_coef = '0;
				op_smp  = '0;
			end
		endcase
	end

	assign mac_ctrl.issue = (state_q == ST_MAC);
	assign mac_ctrl.first = (tap_q == TAP_B0);

	cbq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (op_coef),
		.smp    (op_smp),
		.y      (mac_y)
	);

	// sequencer over sections and taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sec_q     <= '0;
			tap_q     <= TAP_B0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (wet.valid && wet.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						sec_q   <= '0;
						tap_q   <= TAP_B0;
						state_q <= order_ok ? ST_MAC : ST_OUT;
					end
				end
				ST_MAC: begin
					if (tap_q == last_tap) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + TAP_BITS'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					tap_q <= TAP_B0;
					if (sec_q == last_sec) begin
						state_q <= ST_OUT;
					end else begin
						sec_q   <= sec_q + SEC_BITS'(1);
						state_q <= ST_MAC;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// running section input and result register
	always_ff @(posedge clk) begin
		if (in_take) begin
			s_q <= dry.sample_in;
		end else if (state_q == ST_WB) begin
			s_q <= mac_y;
		end
		if (out_load) begin
			out_q <= s_q;
		end
	end

	// section histories, updated once per section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SECTIONS; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else if (state_q == ST_WB) begin
			if (second) begin
				xh2_q[sec_q] <= xh1_q[sec_q];
				yh2_q[sec_q] <= yh1_q[sec_q];
			end
			xh1_q[sec_q] <= s_q;
			yh1_q[sec_q] <= mac_y;
		end
	end

	assign wet.valid      = out_vld_q;
	assign wet.sample_out = out_q;

	// section index stays within the configured cascade
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (sec_q <= last_sec))
		else $error("section index beyond cascade length");

	// write-back only after the accumulator has drained
	a_wb_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> ($past(state_q) == ST_DRAIN))
		else $error("write-back without drain cycle");

	// a new result appears only when leaving the output state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_OUT))
		else $error("result valid raised outside output state");

	// no new sample is taken while the cascade is busy
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC || state_q == ST_DRAIN || state_q == ST_WB) |-> !dry.ready)
		else $error("input ready while computing");

endmodule

`default_nettype wire

// ----- verif/tb_cascaded_biquad_filter.sv -----
`timescale 1ns / 100ps

module tb_cascaded_biquad_filter;
	import cbq_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 50;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PHASES  = 15;
	localparam int PHASE_ITEMS    = 50;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic [ORDER_BITS-1:0] ORDER_BYPASS_LOW  = 2'd0;
	localparam logic [ORDER_BITS-1:0] ORDER_BYPASS_HIGH = 2'd3;

	localparam logic signed [COEF_BITS-1:0] COEF_HALF    = 32'sd134217728;
	localparam logic signed [COEF_BITS-1:0] COEF_QUARTER = 32'sd67108864;
	localparam logic signed [COEF_BITS-1:0] COEF_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [COEF_BITS-1:0] COEF_MIN     = 32'sh8000_0000;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7F_FFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh80_0000;

	localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COEF_BITS-1:0]    cfg_data;

	cbq_in_if  dry_if ();
	cbq_out_if wet_if ();

	cascaded_biquad_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.dry       (dry_if),
		.wet       (wet_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of the registers and section histories
	logic signed [COEF_BITS-1:0]   k_b0, k_b1, k_b2, k_a1, k_a2;
	logic [EXTRA_BITS-1:0]         stage_extra;
	logic [ORDER_BITS-1:0]         mode_order;
	logic signed [SAMPLE_BITS-1:0] past_in1 [NUM_SECTIONS] = '{default: '0};
	logic signed [SAMPLE_BITS-1:0] past_in2 [NUM_SECTIONS] = '{default: '0};
	logic signed [SAMPLE_BITS-1:0] past_out1 [NUM_SECTIONS] = '{default: '0};
	logic signed [SAMPLE_BITS-1:0] past_out2 [NUM_SECTIONS] = '{default: '0};

	logic signed [SAMPLE_BITS-1:0] filtered_q [$];

	int  mismatches = 0;
	int  samples_taken = 0;
	int  results_checked = 0;
	int  settings_count;
	int  quiet_cycles = 0;
	int  hold_request = 0;
	int  hold_granted = 0;
	int  sink_hold = 0;
	bit  src_gaps_on;
	bit  sink_stalls_on;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run one sample through the sections in use, updating their histories
	function automatic logic signed [SAMPLE_BITS-1:0] run_cascade(
			input logic signed [SAMPLE_BITS-1:0] x);
		logic signed [SAMPLE_BITS-1:0] s;
		longint acc;
		int count;
		s = x;
		count = int'(stage_extra) + 1;
		if (count > NUM_SECTIONS)
			count = NUM_SECTIONS;
		if (mode_order == ORDER_FIRST || mode_order == ORDER_SECOND) begin
			for (int k = 0; k < count; k++) begin
				acc = longint'(k_b0) * longint'(s)
					+ longint'(k_b1) * longint'(past_in1[k])
					+ longint'(k_a1) * longint'(past_out1[k]);
				if (mode_order == ORDER_SECOND)
					acc = acc + longint'(k_b2) * longint'(past_in2[k])
						+ longint'(k_a2) * longint'(past_out2[k]);
				// round half up, then clamp to the sample range
				acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
				if (acc > SAT_HI)
					acc = SAT_HI;
				else if (acc < SAT_LO)
					acc = SAT_LO;
				if (mode_order == ORDER_SECOND) begin
					past_in2[k]  = past_in1[k];
					past_out2[k] = past_out1[k];
				end
				past_in1[k]  = s;
				past_out1[k] = acc[SAMPLE_BITS-1:0];
				s = acc[SAMPLE_BITS-1:0];
			end
		end
		return s;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		logic [31:0] bits;
		int r;
		bits = $urandom();
		r = $urandom_range(0, 9);
		if (r == 0)
			return SMP_MAX;
		if (r == 1)
			return SMP_MIN;
		if (r == 2)
			return SAMPLE_BITS'($urandom_range(0, 200)) - 24'sd100;
		return bits[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [COEF_BITS-1:0] random_coef(input int style);
		int r;
		case (style)
			0: return $urandom();
			1: return COEF_BITS'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
			default: begin
				r = $urandom_range(0, 4);
				if (r == 0)
					return COEF_MAX;
				if (r == 1)
					return COEF_MIN;
				if (r == 2)
					return COEF_UNITY;
				if (r == 3)
					return -COEF_UNITY;
				return '0;
			end
		endcase
	endfunction

	// take each accepted request into the predictor
	always @(posedge clk) begin
		if (arst_n && dry_if.valid && dry_if.ready) begin
			filtered_q.push_back(run_cascade(dry_if.sample_in));
			samples_taken++;
		end
	end

	// compare each filtered sample with the oldest prediction
	always @(posedge clk) begin : check_wet
		logic signed [SAMPLE_BITS-1:0] want;
		if (arst_n && wet_if.valid && wet_if.ready) begin
			if (filtered_q.size() == 0) begin
				$error("sample_out expected none got %0d", wet_if.sample_out);
				mismatches++;
			end else begin
				want = filtered_q.pop_front();
				results_checked++;
				if (wet_if.sample_out !== want) begin
					$error("sample_out expected %0d got %0d", want, wet_if.sample_out);
					mismatches++;
				end
			end
		end
	end

	// output side: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_request != hold_granted) begin
			sink_hold = HOLD_CYCLES;
			hold_granted = hold_request;
		end
		if (sink_hold == 0 && sink_stalls_on)
			sink_hold = idle_gap();
		if (sink_hold > 0) begin
			wet_if.ready <= 1'b0;
			sink_hold--;
		end else begin
			wet_if.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (dry_if.valid && dry_if.ready)
				|| (wet_if.valid && wet_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no traffic", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// offer one sample and wait for its request to be taken
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		int gap;
		gap = src_gaps_on ? idle_gap() : 0;
		if (gap > 0) begin
			dry_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dry_if.valid     <= 1'b1;
		dry_if.sample_in <= smp;
		@(posedge clk);
		while (!dry_if.ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every prediction has been matched
	task automatic settle();
		dry_if.valid <= 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_B0:    k_b0 = value;
			REG_B1:    k_b1 = value;
			REG_B2:    k_b2 = value;
			REG_A1:    k_a1 = value;
			REG_A2:    k_a2 = value;
			REG_EXTRA: stage_extra = value[EXTRA_BITS-1:0];
			REG_ORDER: mode_order = value[ORDER_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] b0, b1, b2, a1, a2,
			input logic [31:0] extra, order);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_EXTRA, extra);
		write_reg(REG_ORDER, order);
		settings_count++;
	endtask

	// unity pass-through straight out of reset
	task automatic test_reset_defaults();
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample('0);
		send_sample(24'sd1);
		send_sample(-24'sd1);
		settle();
	endtask

	// ties round upward, large gains clamp both ways
	task automatic test_rounding_and_saturation();
		apply_settings(COEF_HALF, '0, '0, '0, '0, 0, ORDER_SECOND);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_sample(24'sd1);
		send_sample(-24'sd1);
		send_sample(24'sd3);
		send_sample(-24'sd3);
		settle();
		apply_settings(COEF_MAX, '0, '0, '0, '0, 0, ORDER_SECOND);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		settle();
		apply_settings(COEF_MIN, '0, '0, '0, '0, 0, ORDER_SECOND);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		settle();
	endtask

	// bypass codes, first order and second order on the same taps
	task automatic test_filter_orders();
		apply_settings(COEF_UNITY, COEF_HALF, -COEF_QUARTER, COEF_HALF, -COEF_QUARTER,
			1, ORDER_BYPASS_LOW);
		send_sample(24'sd1000);
		send_sample(-24'sd5000);
		settle();
		write_reg(REG_ORDER, ORDER_BYPASS_HIGH);
		send_sample(24'sd12345);
		settle();
		write_reg(REG_ORDER, ORDER_FIRST);
		send_sample(24'sd400000);
		send_sample(-24'sd70000);
		settle();
		write_reg(REG_ORDER, ORDER_SECOND);
		send_sample(24'sd2000000);
		send_sample(SMP_MIN);
		settle();
	endtask

	// section count changes keep history, counts past six clamp
	task automatic test_section_count();
		apply_settings(COEF_UNITY, COEF_HALF, COEF_QUARTER, -COEF_HALF, COEF_QUARTER,
			2, ORDER_SECOND);
		send_sample(24'sd300000);
		send_sample(-24'sd90000);
		settle();
		write_reg(REG_EXTRA, 0);
		send_sample(24'sd50000);
		settle();
		write_reg(REG_EXTRA, 7);
		send_sample(24'sd777777);
		send_sample(-24'sd123456);
		settle();
		write_reg(REG_EXTRA, 6);
		send_sample(24'sd1);
		settle();
	endtask

	// hold the output off while samples keep coming
	task automatic test_output_backpressure();
		apply_settings(COEF_UNITY, COEF_HALF, '0, COEF_QUARTER, '0, 5, ORDER_SECOND);
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		hold_request++;
		repeat (12) send_sample(random_sample());
		settle();
	endtask

	// random settings, each followed by a burst of random samples
	task automatic test_random_settings();
		int style;
		int pick;
		logic [31:0] extra_word;
		logic [31:0] order_word;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			style = $urandom_range(0, 2);
			extra_word = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0)
				extra_word = extra_word | ($urandom() << EXTRA_BITS);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				order_word = ORDER_SECOND;
			else if (pick < 8)
				order_word = ORDER_FIRST;
			else if (pick == 8)
				order_word = ORDER_BYPASS_LOW;
			else
				order_word = ORDER_BYPASS_HIGH;
			if ($urandom_range(0, 3) == 0)
				order_word = order_word | ($urandom() << ORDER_BITS);
			// first phases pin the deepest cascade in both orders
			if (p == 0) begin
				style = 0;
				extra_word = 5;
				order_word = ORDER_SECOND;
			end else if (p == 1) begin
				extra_word = 7;
				order_word = ORDER_FIRST;
			end
			src_gaps_on    = (p != 0) && ($urandom_range(0, 3) != 0);
			sink_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
			apply_settings(random_coef(style), random_coef(style), random_coef(style),
				random_coef(style), random_coef(style), extra_word, order_word);
			repeat (PHASE_ITEMS) send_sample(random_sample());
			settle();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		dry_if.valid     = 1'b0;
		dry_if.sample_in = '0;
		settings_count   = 0;
		src_gaps_on      = 1'b0;
		sink_stalls_on   = 1'b0;
		// reset values of the predictor
		k_b0        = COEF_UNITY;
		k_b1        = '0;
		k_b2        = '0;
		k_a1        = '0;
		k_a2        = '0;
		stage_extra = '0;
		mode_order  = ORDER_SECOND;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		test_rounding_and_saturation();
		test_filter_orders();
		test_section_count();
		test_output_backpressure();
		test_random_settings();

		$display("covered %0d samples, %0d checked results, %0d register settings",
			samples_taken, results_checked, settings_count);
		$display("orders 0 to 3, section counts 1 to 8, coefficient extremes, output hold-off");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/cbq_pkg.sv
rtl/core/cbq_stream_if.sv
rtl/core/cbq_mac.sv
rtl/core/cascaded_biquad_filter.sv
verif/tb_cascaded_biquad_filter.sv
